/* src/nrps_pkg.sv */
// Shared types and constants for the nearest ready point selector.
`timescale 1ns / 1ps
`default_nettype none

package nrps_pkg;

   // Table size and coordinate width.
   localparam int NUM_POINTS    = 32;
   localparam int COORD_BITS    = 8;

   // Fixed widths of the entry index field and the distance limit.
   localparam int INDEX_BITS    = 5;
   localparam int LIMIT_BITS    = 18;

   // Widths derived from the table size and coordinate width.
   localparam int CELL_IDX_BITS = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
   localparam int DIST_BITS     = 2 * COORD_BITS + 1;
   localparam int BEST_BITS     = (DIST_BITS > LIMIT_BITS) ? DIST_BITS : LIMIT_BITS;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(50000);

   // Request opcodes.
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SELECT = 1'b1;

   typedef struct packed {
      logic                         opcode;
      logic [INDEX_BITS-1:0]        entry_index;
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic                         point_ready;
      logic signed [COORD_BITS-1:0] car_x;
      logic signed [COORD_BITS-1:0] car_y;
   } req_type;

   typedef struct packed {
      logic                         found;
      logic [INDEX_BITS-1:0]        chosen_index;
      logic signed [COORD_BITS-1:0] chosen_x;
      logic signed [COORD_BITS-1:0] chosen_y;
   } rsp_type;

   // Search record that moves one cell down the chain each cycle.
   typedef struct packed {
      logic                         valid;
      logic signed [COORD_BITS-1:0] car_x;
      logic signed [COORD_BITS-1:0] car_y;
      logic [BEST_BITS-1:0]         best_dist;
      logic                         have;
      logic [CELL_IDX_BITS-1:0]     idx;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } search_type;

   // Per-cell update controls from the top level.
   typedef struct packed {
      logic                         wr_en;
      logic                         clr_en;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic                         ready;
   } cell_ctrl_type;

endpackage

`default_nettype wire

/* src/nearest_ready_point_select.sv */
// Top level of the nearest ready point selector: request decode, cell chain and result.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// A request is taken at a rising clock edge where start is high and busy is low.
// A load request (opcode OP_LOAD) writes the point and ready mark of one table
// entry at that edge; it produces no result and leaves busy low, so loads can
// be issued on every cycle while no select is in progress. A select request
// (opcode OP_SELECT) launches a search record into a chain of NUM_POINTS
// cells. Each cell holds one entry, computes the squared distance from its
// point to the car and keeps the better candidate in the record, which moves
// one cell per cycle. When the record leaves the last cell, it is shown on
// rsp_data for one cycle with rsp_valid high and is taken at the edge that
// ends that cycle, where the chosen entry's ready mark is also cleared. The
// chain length sets how long a select occupies the block.
// busy is high from the select edge until the result cycle ends.
// The receiver cannot stall the result: it must take it in its one cycle.
// csr_wr_en writes the distance limit; do so only while the block is idle.
// Reset clears all ready marks, empties the chain and loads the limit with
// its reset value; coordinates are undefined until loaded.

module nearest_ready_point_select
   import nrps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [LIMIT_BITS-1:0] csr_wr_data
);

   logic [LIMIT_BITS-1:0] limit_ff;
   logic                  busy_ff;
   logic                  busy_in;
   logic                  accept;
   logic                  do_load;
   logic                  do_select;

   // chain[0] is the launch record, chain[NUM_POINTS] the finished record.
   search_type            chain [NUM_POINTS+1];
   search_type            last;

   assign accept    = start && !busy_ff;
   assign do_load   = accept && (req_data.opcode == OP_LOAD);
   assign do_select = accept && (req_data.opcode == OP_SELECT);

   // The launch record starts at the limit, so only strictly closer points win.
   always_comb begin
      chain[0].valid     = do_select;
      chain[0].car_x     = req_data.car_x;
      chain[0].car_y     = req_data.car_y;
      chain[0].best_dist = BEST_BITS'(limit_ff);
      chain[0].have      = 1'b0;
      chain[0].idx       = '0;
      chain[0].x         = '0;
      chain[0].y         = '0;
   end

   assign last = chain[NUM_POINTS];

   for (genvar i = 0; i < NUM_POINTS; i++) begin : g_cell
      cell_ctrl_type ctrl;

      // A load index beyond the table matches no cell and is dropped.
      always_comb begin
         ctrl.wr_en  = do_load && (int'(req_data.entry_index) == i);
         ctrl.clr_en = last.valid && last.have && (int'(last.idx) == i);
         ctrl.x      = req_data.point_x;
         ctrl.y      = req_data.point_y;
         ctrl.ready  = req_data.point_ready;
      end

      nrps_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (CELL_IDX_BITS'(i)),
         .ctrl       (ctrl),
         .search_in  (chain[i]),
         .search_out (chain[i+1])
      );
   end

   // Busy covers a select from its request edge through the cycle its result is shown.
   always_comb begin
      busy_in = busy_ff;
      if (do_select) begin
         busy_in = 1'b1;
      end else if (last.valid) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         limit_ff <= LIMIT_RESET;
      end else begin
         busy_ff <= busy_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   // Fields stay zero in the record unless a candidate was taken.
   assign busy                  = busy_ff;
   assign rsp_valid             = last.valid;
   assign rsp_data.found        = last.have;
   assign rsp_data.chosen_index = INDEX_BITS'(last.idx);
   assign rsp_data.chosen_x     = last.x;
   assign rsp_data.chosen_y     = last.y;

endmodule

`default_nettype wire

/* src/nrps_cell.sv */
// One table cell: holds a point and its ready mark and updates the passing search record.
`timescale 1ns / 1ps
`default_nettype none

module nrps_cell
   import nrps_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [CELL_IDX_BITS-1:0] cell_idx,
   input  wire cell_ctrl_type            ctrl,
   input  wire search_type               search_in,
   output search_type                    search_out
);

   logic signed [COORD_BITS-1:0] px_ff;
   logic signed [COORD_BITS-1:0] py_ff;
   logic                         ready_ff;
   logic                         ready_in;
   search_type                   out_ff;
   search_type                   out_in;

   logic signed [COORD_BITS:0]   diff_x;
   logic signed [COORD_BITS:0]   diff_y;
   logic [COORD_BITS:0]          abs_x;
   logic [COORD_BITS:0]          abs_y;
   logic [COORD_BITS-1:0]        mag_x;
   logic [COORD_BITS-1:0]        mag_y;
   logic [2*COORD_BITS-1:0]      sq_x;
   logic [2*COORD_BITS-1:0]      sq_y;
   logic [DIST_BITS-1:0]         sq_dist;
   logic                         hit;

   // Exact squared distance; magnitudes fit COORD_BITS unsigned bits.
   assign diff_x = {px_ff[COORD_BITS-1], px_ff} - {search_in.car_x[COORD_BITS-1], search_in.car_x};
   assign diff_y = {py_ff[COORD_BITS-1], py_ff} - {search_in.car_y[COORD_BITS-1], search_in.car_y};
   assign abs_x  = diff_x[COORD_BITS] ? (~diff_x + 1'b1) : diff_x;
   assign abs_y  = diff_y[COORD_BITS] ? (~diff_y + 1'b1) : diff_y;
   assign mag_x  = abs_x[COORD_BITS-1:0];
   assign mag_y  = abs_y[COORD_BITS-1:0];
   assign sq_x   = mag_x * mag_x;
   assign sq_y   = mag_y * mag_y;
   assign sq_dist = {1'b0, sq_x} + {1'b0, sq_y};

   // Strict compare keeps the lower index on a tie.
   assign hit = search_in.valid && ready_ff && (BEST_BITS'(sq_dist) < search_in.best_dist);

   always_comb begin
      out_in = search_in;
      if (hit) begin
         out_in.best_dist = BEST_BITS'(sq_dist);
         out_in.have      = 1'b1;
         out_in.idx       = cell_idx;
         out_in.x         = px_ff;
         out_in.y         = py_ff;
      end
   end

   always_comb begin
      ready_in = ready_ff;
      if (ctrl.wr_en) begin
         ready_in = ctrl.ready;
      end else if (ctrl.clr_en) begin
         ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff     <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         ready_ff     <= ready_in;
         out_ff.valid <= out_in.valid;
      end
      out_ff.car_x     <= out_in.car_x;
      out_ff.car_y     <= out_in.car_y;
      out_ff.best_dist <= out_in.best_dist;
      out_ff.have      <= out_in.have;
      out_ff.idx       <= out_in.idx;
      out_ff.x         <= out_in.x;
      out_ff.y         <= out_in.y;
      if (ctrl.wr_en) begin
         px_ff <= ctrl.x;
         py_ff <= ctrl.y;
      end
   end

   assign search_out = out_ff;

endmodule

`default_nettype wire
